>>> sv/mtp_pkg.sv
// Shared types and codes for the MIDI track event parser.
package mtp_pkg;

    // parser phases
    localparam logic [2:0] PH_TIME      = 3'd0;
    localparam logic [2:0] PH_TIMECONT  = 3'd1;
    localparam logic [2:0] PH_STATUS    = 3'd2;
    localparam logic [2:0] PH_META_TYPE = 3'd3;
    localparam logic [2:0] PH_META_LEN  = 3'd4;
    localparam logic [2:0] PH_DATA      = 3'd5;
    localparam logic [2:0] PH_SYSEX     = 3'd6;

    // byte classes
    localparam logic [2:0] CL_TIME_PART = 3'd0;
    localparam logic [2:0] CL_TIME_DONE = 3'd1;
    localparam logic [2:0] CL_STATUS    = 3'd2;
    localparam logic [2:0] CL_META_TYPE = 3'd3;
    localparam logic [2:0] CL_META_LEN  = 3'd4;
    localparam logic [2:0] CL_DATA      = 3'd5;
    localparam logic [2:0] CL_SYSEX     = 3'd6;
    localparam logic [2:0] CL_ERROR     = 3'd7;

    // status byte values and nibbles
    localparam logic [7:0] ST_META   = 8'hff;
    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_POLY_AT  = 4'ha;
    localparam logic [3:0] HI_CTRL     = 4'hb;
    localparam logic [3:0] HI_PROG     = 4'hc;
    localparam logic [3:0] HI_CHAN_AT  = 4'hd;
    localparam logic [3:0] HI_PITCH    = 4'he;
    localparam logic [3:0] HI_SYSTEM   = 4'hf;

    localparam int DT_W = 28;

    typedef struct packed {
        logic [2:0]      byte_class;
        logic [7:0]      byte_echo;
        logic [DT_W-1:0] delta_time;
        logic            event_end;
        logic            time_overflow;
    } t_result;

endpackage

>>> sv/mtp_parser.sv
// Parser state registers and the per-byte classification step.
module mtp_parser
    import mtp_pkg::*;
#(
    parameter int TIME_BITS = 28
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_chunk_end,
    output t_result    o_result
);

    localparam int TIME_MAX_BYTES = ((TIME_BITS / 7) > 7) ? 7 : (TIME_BITS / 7);

    logic [2:0]           r_phase, n_phase;
    logic [TIME_BITS-1:0] r_accum, n_accum;
    logic [7:0]           r_left, n_left;
    logic [2:0]           r_tcnt, n_tcnt;
    logic                 r_ovf, n_ovf;

    logic [3:0]           hi;
    logic [TIME_BITS+6:0] shifted;
    logic [2:0]           cnt_base;
    logic                 ovf_base;
    logic [TIME_BITS+DT_W-1:0] accum_ext;
    logic [2:0]           cls;
    logic                 ev_end;

    assign hi        = i_data_byte[7:4];
    assign shifted   = {r_accum, i_data_byte[6:0]};
    assign accum_ext = {{DT_W{1'b0}}, n_accum};

    always_comb begin
        n_phase  = r_phase;
        n_accum  = r_accum;
        n_left   = r_left;
        n_tcnt   = r_tcnt;
        n_ovf    = r_ovf;
        cls      = CL_ERROR;
        ev_end   = 1'b0;
        cnt_base = r_tcnt;
        ovf_base = r_ovf;

        case (r_phase)
            PH_TIMECONT: begin
                n_accum = shifted[TIME_BITS-1:0];
            end
            PH_STATUS: begin
                cls = CL_STATUS;
                if (i_data_byte == ST_META) begin
                    n_phase = PH_META_TYPE;
                end else if (hi == HI_PROG || hi == HI_CHAN_AT) begin
                    n_phase = PH_DATA;
                    n_left  = 8'd1;
                end else if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON || hi == HI_POLY_AT ||
                             hi == HI_CTRL || hi == HI_PITCH) begin
                    n_phase = PH_DATA;
                    n_left  = 8'd2;
                end else if (hi == HI_SYSTEM) begin
                    n_phase = PH_SYSEX;
                end else begin
                    cls     = CL_ERROR;
                    ev_end  = 1'b1;
                    n_phase = PH_TIME;
                end
            end
            PH_META_TYPE: begin
                cls     = CL_META_TYPE;
                n_phase = PH_META_LEN;
            end
            PH_META_LEN: begin
                cls    = CL_META_LEN;
                n_left = i_data_byte;
                if (i_data_byte == 8'd0) begin
                    ev_end  = 1'b1;
                    n_phase = PH_TIME;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                cls = CL_DATA;
                if (r_left != 8'd0) begin
                    n_left = r_left - 8'd1;
                end
                if (n_left == 8'd0) begin
                    ev_end  = 1'b1;
                    n_phase = PH_TIME;
                end
            end
            PH_SYSEX: begin
                cls = CL_SYSEX;
                if (i_data_byte[7]) begin
                    ev_end  = 1'b1;
                    n_phase = PH_TIME;
                end
            end
            default: begin
                // first time byte of a new event: restart accumulation
                n_accum  = TIME_BITS'(i_data_byte[6:0]);
                cnt_base = 3'd0;
                ovf_base = 1'b0;
            end
        endcase

        // shared time-byte handling for both time phases and the unused phase code
        if (r_phase == PH_TIMECONT || r_phase > PH_SYSEX || r_phase == PH_TIME) begin
            n_ovf  = (cnt_base >= 3'(TIME_MAX_BYTES)) ? 1'b1 : ovf_base;
            n_tcnt = (cnt_base < 3'd7) ? cnt_base + 3'd1 : cnt_base;
            if (!i_data_byte[7]) begin
                cls     = CL_TIME_DONE;
                n_phase = PH_STATUS;
            end else begin
                cls     = CL_TIME_PART;
                n_phase = PH_TIMECONT;
            end
        end
    end

    assign o_result.byte_class    = cls;
    assign o_result.byte_echo     = i_data_byte;
    assign o_result.delta_time    = accum_ext[DT_W-1:0];
    assign o_result.event_end     = ev_end;
    assign o_result.time_overflow = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TIME;
            r_accum <= '0;
            r_left  <= '0;
            r_tcnt  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_chunk_end) begin
                r_phase <= PH_TIME;
                r_accum <= '0;
                r_left  <= '0;
                r_tcnt  <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_accum <= n_accum;
                r_left  <= n_left;
                r_tcnt  <= n_tcnt;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

>>> sv/mtp_out_buf.sv
// Result register with a skid stage between the parser and the output channel.
module mtp_out_buf
    import mtp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    in_xfer;
    logic    out_free;

    assign o_ready  = !r_skid_vld;
    assign in_xfer  = i_valid && !r_skid_vld;
    assign out_free = !r_out_vld || i_ready;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : i_result;
        end else if (in_xfer) begin
            r_skid <= i_result;
        end
    end

endmodule

>>> sv/midi_track_event_parser.sv
// MIDI track event parser: one track-chunk byte in, one classified result out per cycle
// while the output side takes them, with the byte echoed, the event's delta time
// (TIME_BITS wide internally, low 28 bits shown) and end-of-event and time-overflow
// flags. Each byte goes through the combinational parser step into the result register
// or the skid, so a byte can be accepted every cycle while the skid is empty. A two-entry
// output stage (result register plus skid) keeps input ready high while one result
// waits, so input stalls only after the output side has held off for two results.
// Asserting i_chunk_end on a byte returns the parser to delta-time parsing after that byte.
module midi_track_event_parser
    import mtp_pkg::*;
#(
    parameter int TIME_BITS = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_chunk_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_byte_class,
    output logic [7:0]  o_byte_echo,
    output logic [27:0] o_delta_time,
    output logic        o_event_end,
    output logic        o_time_overflow
);

    t_result step_res;
    t_result out_res;
    logic    in_xfer;

    assign in_xfer = i_valid && o_ready;

    mtp_parser #(
        .TIME_BITS(TIME_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_data_byte (i_data_byte),
        .i_chunk_end (i_chunk_end),
        .o_result    (step_res)
    );

    mtp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_result (step_res),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_res)
    );

    assign o_byte_class    = out_res.byte_class;
    assign o_byte_echo     = out_res.byte_echo;
    assign o_delta_time    = out_res.delta_time;
    assign o_event_end     = out_res.event_end;
    assign o_time_overflow = out_res.time_overflow;

endmodule

>>> sv/mtp_checker.sv
// Port-level checks for the MIDI track event parser, bound to the top level.
module mtp_checker
    import mtp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_byte_class,
    input logic [7:0]  o_byte_echo,
    input logic        o_event_end
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_byte_echo) && $stable(o_byte_class))
        else $error("result changed while stalled");

    // an error always closes the event
    a_err_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_class == CL_ERROR |-> o_event_end)
        else $error("error class without event end");

    // time, status and meta type bytes never end an event
    a_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_byte_class == CL_TIME_PART || o_byte_class == CL_TIME_DONE ||
                    o_byte_class == CL_STATUS || o_byte_class == CL_META_TYPE)
        |-> !o_event_end)
        else $error("event end on a non-final byte class");

    // the time ends on a byte with a clear top bit, continues on a set one
    a_time_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_byte_class == CL_TIME_DONE || o_byte_class == CL_TIME_PART)
        |-> (o_byte_echo[7] == (o_byte_class == CL_TIME_PART)))
        else $error("time byte class does not match continuation bit");

endmodule

bind midi_track_event_parser mtp_checker u_mtp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_byte_class (o_byte_class),
    .o_byte_echo  (o_byte_echo),
    .o_event_end  (o_event_end)
);

>>> verif/tb_midi_track_event_parser.sv
// Testbench for the MIDI track event parser: queued byte stimulus, per-byte prediction, checks.
module tb_midi_track_event_parser
    import mtp_pkg::*;
();

    localparam int TIME_GROUPS_MAX = (DT_W / 7 > 7) ? 7 : DT_W / 7;
    localparam int RANDOM_BYTES    = 1150;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_SPACING   = 300;

    typedef struct {
        logic [7:0] data;
        logic       chunk_end;
        logic       drain;      // hold this byte back until all results are in
    } t_track_byte;

    typedef enum logic [1:0] {STALL_RX_HEAVY, STALL_TX_HEAVY, STALL_NONE} t_stall_mix;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_chunk_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_byte_class;
    logic [7:0]  o_byte_echo;
    logic [27:0] o_delta_time;
    logic        o_event_end;
    logic        o_time_overflow;

    t_track_byte track_bytes[$];
    t_result     expected_results[$];
    int          byte_total;
    int          bytes_sent;
    int          mismatches;
    int          cycles;
    logic        hold_next;
    t_stall_mix  stall_mix = STALL_RX_HEAVY;

    // parser state mirror
    logic [2:0]      pp_phase = PH_TIME;
    logic [DT_W-1:0] pp_time = '0;
    logic [7:0]      pp_left = '0;
    logic [2:0]      pp_groups = '0;
    logic            pp_ovf = 1'b0;

    midi_track_event_parser DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_chunk_end    (i_chunk_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_byte_class   (o_byte_class),
        .o_byte_echo    (o_byte_echo),
        .o_delta_time   (o_delta_time),
        .o_event_end    (o_event_end),
        .o_time_overflow(o_time_overflow)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result classify_byte(input logic [7:0] b, input logic last);
        t_result r;
        r.byte_echo = b;
        r.event_end = 1'b0;
        case (pp_phase)
            PH_STATUS: begin
                r.byte_class = CL_STATUS;
                if (b == ST_META) begin
                    pp_phase = PH_META_TYPE;
                end else begin
                    case (b[7:4])
                        HI_PROG, HI_CHAN_AT: begin
                            pp_phase = PH_DATA;
                            pp_left  = 8'd1;
                        end
                        HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_PITCH: begin
                            pp_phase = PH_DATA;
                            pp_left  = 8'd2;
                        end
                        HI_SYSTEM: pp_phase = PH_SYSEX;
                        default: begin
                            r.byte_class = CL_ERROR;
                            r.event_end  = 1'b1;
                            pp_phase     = PH_TIME;
                        end
                    endcase
                end
            end
            PH_META_TYPE: begin
                r.byte_class = CL_META_TYPE;
                pp_phase     = PH_META_LEN;
            end
            PH_META_LEN: begin
                r.byte_class = CL_META_LEN;
                pp_left      = b;
                if (b == 8'd0) begin
                    r.event_end = 1'b1;
                    pp_phase    = PH_TIME;
                end else begin
                    pp_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                r.byte_class = CL_DATA;
                if (pp_left != 8'd0)
                    pp_left--;
                if (pp_left == 8'd0) begin
                    r.event_end = 1'b1;
                    pp_phase    = PH_TIME;
                end
            end
            PH_SYSEX: begin
                r.byte_class = CL_SYSEX;
                if (b[7]) begin
                    r.event_end = 1'b1;
                    pp_phase    = PH_TIME;
                end
            end
            default: begin
                // continuation group shifts in; anything else starts a new time
                if (pp_phase == PH_TIMECONT) begin
                    pp_time = {pp_time[DT_W-8:0], b[6:0]};
                end else begin
                    pp_time   = DT_W'(b[6:0]);
                    pp_groups = '0;
                    pp_ovf    = 1'b0;
                end
                if (pp_groups >= TIME_GROUPS_MAX)
                    pp_ovf = 1'b1;
                if (pp_groups != 3'd7)
                    pp_groups++;
                if (b[7]) begin
                    r.byte_class = CL_TIME_PART;
                    pp_phase     = PH_TIMECONT;
                end else begin
                    r.byte_class = CL_TIME_DONE;
                    pp_phase     = PH_STATUS;
                end
            end
        endcase
        r.delta_time    = pp_time;
        r.time_overflow = pp_ovf;
        if (last) begin
            pp_phase  = PH_TIME;
            pp_time   = '0;
            pp_left   = '0;
            pp_groups = '0;
            pp_ovf    = 1'b0;
        end
        return r;
    endfunction

    task automatic add_byte(input logic [7:0] d, input logic last);
        track_bytes.push_back('{data: d, chunk_end: last, drain: hold_next});
        hold_next = 1'b0;
    endtask

    // queue a byte run; chunk end goes on byte last_at and the run stops there
    task automatic add_run(input logic [7:0] run[$], input int last_at);
        for (int i = 0; i < run.size(); i++) begin
            add_byte(run[i], i == last_at);
            if (i == last_at)
                break;
        end
    endtask

    task automatic add_random_event();
        logic [7:0] run[$];
        int         kind;
        int         groups;
        int         len;
        int         pick;
        int         last_at;
        logic [3:0] hi;
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            // noise: loose bytes at whatever phase the parser is in
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            return;
        end
        groups = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        for (int i = 0; i < groups - 1; i++)
            run.push_back(8'h80 | 8'($urandom_range(0, 127)));
        run.push_back(8'($urandom_range(0, 127)));
        if (kind < 8) begin
            run.push_back(8'($urandom_range(0, 127)));     // bad status
        end else if (kind < 24) begin
            run.push_back(ST_META);
            run.push_back(8'($urandom_range(0, 255)));
            len = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
            run.push_back(8'(len));
            for (int i = 0; i < len; i++)
                run.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 76) begin
            pick = $urandom_range(0, 6);
            hi   = 4'(HI_NOTE_OFF + pick);
            run.push_back({hi, 4'($urandom_range(0, 15))});
            len = (hi == HI_PROG || hi == HI_CHAN_AT) ? 1 : 2;
            for (int i = 0; i < len; i++)
                run.push_back(8'($urandom_range(0, 255)));
        end else begin
            run.push_back(8'($urandom_range(8'hf0, 8'hfe)));
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++)
                run.push_back(8'($urandom_range(0, 127)));
            run.push_back(8'($urandom_range(128, 255)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            last_at = $urandom_range(0, run.size() - 1);
        else if (pick < 10)
            last_at = run.size() - 1;
        else
            last_at = -1;
        add_run(run, last_at);
    endtask

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_track_byte nxt;
        logic        present;
        int          gap_pct;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            present = 1'b0;
            if (i_valid && o_ready) begin
                expected_results.push_back(classify_byte(i_data_byte, i_chunk_end));
                bytes_sent++;
            end
            if (bytes_sent < byte_total / 3)
                stall_mix <= STALL_RX_HEAVY;
            else if (bytes_sent < 2 * byte_total / 3)
                stall_mix <= STALL_TX_HEAVY;
            else
                stall_mix <= STALL_NONE;
            gap_pct = (stall_mix == STALL_RX_HEAVY) ? 8 : (stall_mix == STALL_TX_HEAVY) ? 57 : 0;
            if (!i_valid || o_ready) begin
                if (track_bytes.size() > 0 && $urandom_range(0, 99) >= gap_pct &&
                    !(track_bytes[0].drain && expected_results.size() != 0))
                    present = 1'b1;
                if (present) begin
                    nxt = track_bytes.pop_front();
                    i_data_byte <= nxt.data;
                    i_chunk_end <= nxt.chunk_end;
                end
                i_valid <= present;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        int      stall_pct;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, class %0d byte 0x%0h",
                             $time, o_byte_class, o_byte_echo);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_byte_class !== want.byte_class)
                        report("byte_class", 32'(want.byte_class), 32'(o_byte_class));
                    if (o_byte_echo !== want.byte_echo)
                        report("byte_echo", 32'(want.byte_echo), 32'(o_byte_echo));
                    if (o_delta_time !== want.delta_time)
                        report("delta_time", 32'(want.delta_time), 32'(o_delta_time));
                    if (o_event_end !== want.event_end)
                        report("event_end", 32'(want.event_end), 32'(o_event_end));
                    if (o_time_overflow !== want.time_overflow)
                        report("time_overflow", 32'(want.time_overflow),
                               32'(o_time_overflow));
                end
            end
            stall_pct = (stall_mix == STALL_RX_HEAVY) ? 57 :
                        (stall_mix == STALL_TX_HEAVY) ? 8 : 0;
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL midi_track_event_parser");
            $finish;
        end
    end

    initial begin
        logic [7:0] run[$];
        int         next_drain;
        hold_next  = 1'b0;
        mismatches = 0;
        bytes_sent = 0;
        cycles     = 0;

        // meta end-of-track with zero length
        run = '{8'h00, 8'hff, 8'h2f, 8'h00};
        add_run(run, -1);
        // five time groups: overflow; then program change
        run = '{8'hff, 8'h80, 8'h80, 8'h80, 8'h00, 8'hc0, 8'h7f};
        add_run(run, -1);
        run = '{8'h7f, 8'h8f, 8'h00, 8'hff};
        add_run(run, -1);
        // chunk end in the middle of a controller event
        run = '{8'h00, 8'hb0, 8'h07};
        add_run(run, 2);
        // status without the top bit
        run = '{8'h00, 8'h45};
        add_run(run, -1);
        run = '{8'h00, 8'hf0, 8'h7f, 8'hf7};
        add_run(run, -1);
        run = '{8'h00, 8'hdf, 8'h40};
        add_run(run, -1);
        run = '{8'h00, 8'he0, 8'h00, 8'h7f};
        add_run(run, -1);

        hold_next  = 1'b1;
        next_drain = track_bytes.size() + DRAIN_SPACING;
        while (track_bytes.size() < RANDOM_BYTES + 31) begin
            if (track_bytes.size() >= next_drain) begin
                hold_next  = 1'b1;
                next_drain += DRAIN_SPACING;
            end
            add_random_event();
        end
        byte_total = track_bytes.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (track_bytes.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS midi_track_event_parser");
        else
            $display("FAIL midi_track_event_parser");
        $finish;
    end

endmodule
